// ===== sv/alr_pkg.sv =====
// shared types, codes and defaults for the address lease allocator
`default_nettype none
package alr_pkg;

    localparam int POOL_DEPTH_DEF   = 1024;
    localparam int CLIENT_DEPTH_DEF = 1024;

    localparam int TIME_W   = 31;
    localparam int CLIENT_W = 10;
    localparam int ADDR_W   = 16;
    localparam int EXP_W    = 32;
    localparam int PSIZE_W  = 11;

    localparam logic [1:0] ST_FREE     = 2'd0;
    localparam logic [1:0] ST_PENDING  = 2'd1;
    localparam logic [1:0] ST_OCCUPIED = 2'd2;
    localparam logic [1:0] ST_EXPIRED  = 2'd3;

    localparam logic [1:0] CMD_DISCOVER = 2'd0;
    localparam logic [1:0] CMD_REQUEST  = 2'd1;

    localparam logic [1:0] DEST_BCAST = 2'd0;
    localparam logic [1:0] DEST_HERE  = 2'd1;
    localparam logic [1:0] DEST_OTHER = 2'd2;

    localparam logic [1:0] KIND_OFFER = 2'd0;
    localparam logic [1:0] KIND_ACK   = 2'd1;
    localparam logic [1:0] KIND_NAK   = 2'd2;

    localparam logic [1:0] CFG_POOL_SIZE = 2'd0;
    localparam logic [1:0] CFG_DEFAULT   = 2'd1;
    localparam logic [1:0] CFG_MAX       = 2'd2;
    localparam logic [1:0] CFG_MIN       = 2'd3;

    localparam logic [PSIZE_W-1:0] RST_POOL_SIZE = 11'd1024;
    localparam logic [TIME_W-1:0]  RST_DEFAULT   = 31'd3600;
    localparam logic [TIME_W-1:0]  RST_MAX       = 31'd86400;
    localparam logic [TIME_W-1:0]  RST_MIN       = 31'd60;

    typedef struct packed {
        logic [1:0]          status;
        logic [CLIENT_W-1:0] owner;
        logic [EXP_W-1:0]    expiry;
    } entry_t;

endpackage
`default_nettype wire

// ===== sv/alr_ram.sv =====
// generic single-port-write ram with registered read
`default_nettype none
module alr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== sv/alr_cell.sv =====
// one pool entry of the circulating lease chain
`default_nettype none
module alr_cell (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          shift_en,
    input  wire alr_pkg::entry_t d_in,
    output alr_pkg::entry_t    q_out
);
    alr_pkg::entry_t entry_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= '0;
        end
        else if (shift_en)
        begin
            entry_reg <= d_in;
        end
    end

    assign q_out = entry_reg;
endmodule
`default_nettype wire

// ===== sv/alr_chain.sv =====
// ring of entry cells, head entry leaves at the end and re-enters at the front
`default_nettype none
module alr_chain #(
    parameter int DEPTH = alr_pkg::POOL_DEPTH_DEF
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            shift_en,
    input  wire alr_pkg::entry_t head_in,
    output alr_pkg::entry_t      head_out
);
    alr_pkg::entry_t link [DEPTH+1];

    assign link[0] = head_in;

    for (genvar k = 0; k < DEPTH; k++)
    begin : g_cell
        alr_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .shift_en (shift_en),
            .d_in     (link[k]),
            .q_out    (link[k+1])
        );
    end

    assign head_out = link[DEPTH];
endmodule
`default_nettype wire

// ===== sv/address_lease_allocator_core.sv =====
// top level of the address lease allocator
//
// channels: a message is a transaction taken when start is high and busy is low;
// its fields are sampled on that edge. a result appears for one cycle with
// reply_valid high; the receiver cannot stall, so it must take it then.
// configuration writes use cfg_valid/cfg_ready (ready is always high) with
// cfg_index selecting pool_size, default_lease, lease_max or lease_min;
// write only while busy is low.
// the pool lives in a ring of POOL_DEPTH cells that rotates one entry per
// cycle during a lap past a single head update unit. every message takes two
// full laps: the first sweeps expiry and finds the client's own, lowest free
// and lowest expired entries; the second applies the allocation, acknowledge
// or release. each lap follows a ram read and a capture step; a final step
// registers the reply. busy drops in the reply cycle, so the next message can
// be taken at the edge that ends it; none is taken while one is in flight.
// per-client last address sits in a ram; after reset the block stays busy
// while it clears all CLIENT_DEPTH entries (1024 at defaults).
`default_nettype none
module address_lease_allocator_core #(
    parameter int POOL_DEPTH   = alr_pkg::POOL_DEPTH_DEF,
    parameter int CLIENT_DEPTH = alr_pkg::CLIENT_DEPTH_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic [alr_pkg::TIME_W-1:0]     msg_time,
    input  wire logic [alr_pkg::CLIENT_W-1:0]   client_id,
    input  wire logic                           sender_is_client,
    input  wire logic [1:0]                     destination,
    input  wire logic [1:0]                     command,
    input  wire logic [alr_pkg::ADDR_W-1:0]     address,
    input  wire logic [alr_pkg::TIME_W-1:0]     requested_expiry,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [1:0]                     cfg_index,
    input  wire logic [alr_pkg::TIME_W-1:0]     cfg_data,
    output logic                                reply_valid,
    output logic [1:0]                          reply_kind,
    output logic [alr_pkg::CLIENT_W-1:0]        reply_client,
    output logic [alr_pkg::ADDR_W-1:0]          reply_address,
    output logic [alr_pkg::EXP_W-1:0]           reply_expiry
);
    localparam int PW = $clog2(POOL_DEPTH + 1);
    localparam int CW = $clog2(CLIENT_DEPTH);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_CLEAR = 9'b000000010,
        S_RD1   = 9'b000000100,
        S_CAP1  = 9'b000001000,
        S_LAP1  = 9'b000010000,
        S_RD2   = 9'b000100000,
        S_CAP2  = 9'b001000000,
        S_LAP2  = 9'b010000000,
        S_FIN   = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [alr_pkg::PSIZE_W-1:0] pool_size_reg;
    logic [alr_pkg::TIME_W-1:0]  default_reg, max_reg, min_reg;

    // captured message
    logic [alr_pkg::TIME_W-1:0]   time_reg, req_reg;
    logic [alr_pkg::CLIENT_W-1:0] client_reg;
    logic [alr_pkg::ADDR_W-1:0]   addr_reg;
    logic disc_reg, here_reg, else_reg;

    // lap control and search results
    logic [PW-1:0] idx_reg, idx_next;
    logic [CW-1:0] clr_reg, clr_next;
    logic [PW-1:0] own_reg, own_next, ca2_reg, ca2_next;
    logic          own_hit_reg, own_hit_next, c_clr_reg, c_clr_next;
    logic          free_hit_reg, free_hit_next, exp_hit_reg, exp_hit_next;
    logic [PW-1:0] free_idx_reg, free_idx_next, exp_idx_reg, exp_idx_next;
    logic [PW-1:0] sel_reg, sel_next;
    logic          sel_ok_reg, sel_ok_next;
    logic          ack_reg, ack_next, rel_reg, rel_next;
    logic [alr_pkg::EXP_W-1:0] def_reg, lo_reg, hi_reg, grant_reg, grant_next;

    // reply
    logic                         rv_reg, rv_next;
    logic [1:0]                   rk_reg, rk_next;
    logic [alr_pkg::ADDR_W-1:0]   ra_reg, ra_next;
    logic [alr_pkg::EXP_W-1:0]    re_reg, re_next;

    // ring and ram
    alr_pkg::entry_t head_out, head_in;
    logic            shift_en;
    logic            ram_we;
    logic [CW-1:0]   ram_waddr;
    logic [PW-1:0]   ram_wdata, ram_rdata;

    logic accept, in_pool, last_idx, due, cl_ok;
    logic [alr_pkg::EXP_W-1:0] req32;

    function automatic logic [alr_pkg::ADDR_W-1:0] ADDR_CAST(input logic [PW-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        return w[alr_pkg::ADDR_W-1:0];
    endfunction

    assign accept    = start && !busy;
    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign shift_en  = (state_reg == S_LAP1) || (state_reg == S_LAP2);
    assign in_pool   = (32'(idx_reg) <= 32'(pool_size_reg));
    assign last_idx  = (idx_reg == PW'(POOL_DEPTH));
    assign due       = ({1'b0, time_reg} >= head_out.expiry);
    assign req32     = {1'b0, req_reg};
    assign cl_ok     = sender_is_client && (client_id != '0)
                       && (32'(client_id) < 32'(CLIENT_DEPTH));

    alr_chain #(.DEPTH(POOL_DEPTH)) u_chain (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (shift_en),
        .head_in  (head_in),
        .head_out (head_out)
    );

    alr_ram #(.WIDTH(PW), .DEPTH(CLIENT_DEPTH)) u_ca_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (CW'(client_reg)),
        .rdata (ram_rdata)
    );

    // head update, search and sequencing
    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        clr_next      = clr_reg;
        own_next      = own_reg;
        ca2_next      = ca2_reg;
        own_hit_next  = own_hit_reg;
        c_clr_next    = c_clr_reg;
        free_hit_next = free_hit_reg;
        free_idx_next = free_idx_reg;
        exp_hit_next  = exp_hit_reg;
        exp_idx_next  = exp_idx_reg;
        sel_next      = sel_reg;
        sel_ok_next   = sel_ok_reg;
        ack_next      = ack_reg;
        rel_next      = rel_reg;
        grant_next    = grant_reg;
        rv_next       = 1'b0;
        rk_next       = rk_reg;
        ra_next       = ra_reg;
        re_next       = re_reg;
        head_in       = head_out;
        ram_we        = 1'b0;
        ram_waddr     = CW'(client_reg);
        ram_wdata     = '0;

        case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == CW'(CLIENT_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_RD1;
                end
            end
            S_RD1:
            begin
                state_next = S_CAP1;
            end
            S_CAP1:
            begin
                own_next      = ram_rdata;
                own_hit_next  = 1'b0;
                c_clr_next    = 1'b0;
                free_hit_next = 1'b0;
                exp_hit_next  = 1'b0;
                idx_next      = PW'(1);
                state_next    = S_LAP1;
            end
            S_LAP1:
            begin
                // expiry sweep
                if (in_pool && due && (head_out.status == alr_pkg::ST_PENDING))
                begin
                    head_in = '0;
                    if (32'(head_out.owner) < 32'(CLIENT_DEPTH))
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = CW'(head_out.owner);
                    end
                    if (head_out.owner == client_reg)
                    begin
                        c_clr_next = 1'b1;
                    end
                end
                else if (in_pool && due && (head_out.status == alr_pkg::ST_OCCUPIED))
                begin
                    head_in.status = alr_pkg::ST_EXPIRED;
                    head_in.expiry = '0;
                end
                // search over swept values
                if (in_pool)
                begin
                    if ((idx_reg == own_reg) && (head_in.owner == client_reg))
                    begin
                        own_hit_next = 1'b1;
                    end
                    if (!free_hit_reg && (head_in.status == alr_pkg::ST_FREE))
                    begin
                        free_hit_next = 1'b1;
                        free_idx_next = idx_reg;
                    end
                    if (!exp_hit_reg && (head_in.status == alr_pkg::ST_EXPIRED))
                    begin
                        exp_hit_next = 1'b1;
                        exp_idx_next = idx_reg;
                    end
                end
                idx_next = idx_reg + 1'b1;
                if (last_idx)
                begin
                    state_next = S_RD2;
                end
            end
            S_RD2:
            begin
                sel_ok_next = 1'b1;
                if (own_hit_reg && !c_clr_reg)
                begin
                    sel_next = own_reg;
                end
                else if (free_hit_reg)
                begin
                    sel_next = free_idx_reg;
                end
                else if (exp_hit_reg)
                begin
                    sel_next = exp_idx_reg;
                end
                else
                begin
                    sel_ok_next = 1'b0;
                end
                state_next = S_CAP2;
            end
            S_CAP2:
            begin
                ca2_next = ram_rdata;
                if (req_reg == '0)
                begin
                    grant_next = def_reg;
                end
                else if (req32 > hi_reg)
                begin
                    grant_next = hi_reg;
                end
                else if (req32 < lo_reg)
                begin
                    grant_next = (lo_reg > hi_reg) ? hi_reg : lo_reg;
                end
                else
                begin
                    grant_next = req32;
                end
                ack_next   = 1'b0;
                rel_next   = 1'b0;
                idx_next   = PW'(1);
                state_next = S_LAP2;
            end
            S_LAP2:
            begin
                if (disc_reg && sel_ok_reg && (idx_reg == sel_reg))
                begin
                    head_in.status = alr_pkg::ST_PENDING;
                    head_in.owner  = client_reg;
                    head_in.expiry = grant_reg;
                end
                if (here_reg && in_pool && (32'(idx_reg) == 32'(addr_reg))
                    && (head_out.owner == client_reg))
                begin
                    head_in.status = alr_pkg::ST_OCCUPIED;
                    head_in.expiry = grant_reg;
                    ack_next       = 1'b1;
                end
                if (else_reg && in_pool && (head_out.status == alr_pkg::ST_PENDING)
                    && (head_out.owner == client_reg))
                begin
                    head_in = '0;
                    if (idx_reg == ca2_reg)
                    begin
                        rel_next = 1'b1;
                    end
                end
                idx_next = idx_reg + 1'b1;
                if (last_idx)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (disc_reg && sel_ok_reg)
                begin
                    ram_we    = 1'b1;
                    ram_wdata = sel_reg;
                    rv_next   = 1'b1;
                    rk_next   = alr_pkg::KIND_OFFER;
                    ra_next   = ADDR_CAST(sel_reg);
                    re_next   = grant_reg;
                end
                if (else_reg && rel_reg)
                begin
                    ram_we = 1'b1;
                end
                if (here_reg)
                begin
                    rv_next = 1'b1;
                    ra_next = addr_reg;
                    rk_next = ack_reg ? alr_pkg::KIND_ACK : alr_pkg::KIND_NAK;
                    re_next = ack_reg ? grant_reg : '0;
                end
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            rv_reg        <= 1'b0;
            pool_size_reg <= alr_pkg::RST_POOL_SIZE;
            default_reg   <= alr_pkg::RST_DEFAULT;
            max_reg       <= alr_pkg::RST_MAX;
            min_reg       <= alr_pkg::RST_MIN;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            rv_reg    <= rv_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    alr_pkg::CFG_POOL_SIZE: pool_size_reg <= cfg_data[alr_pkg::PSIZE_W-1:0];
                    alr_pkg::CFG_DEFAULT:   default_reg   <= cfg_data;
                    alr_pkg::CFG_MAX:       max_reg       <= cfg_data;
                    alr_pkg::CFG_MIN:       min_reg       <= cfg_data;
                    default:                ;
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            time_reg   <= msg_time;
            req_reg    <= requested_expiry;
            client_reg <= client_id;
            addr_reg   <= address;
            disc_reg   <= cl_ok && (command == alr_pkg::CMD_DISCOVER)
                          && (destination == alr_pkg::DEST_BCAST);
            here_reg   <= cl_ok && (command == alr_pkg::CMD_REQUEST)
                          && (destination == alr_pkg::DEST_HERE);
            else_reg   <= cl_ok && (command == alr_pkg::CMD_REQUEST)
                          && (destination == alr_pkg::DEST_OTHER);
        end
        if (state_reg == S_CAP1)
        begin
            def_reg <= {1'b0, time_reg} + {1'b0, default_reg};
            lo_reg  <= {1'b0, time_reg} + {1'b0, min_reg};
            hi_reg  <= {1'b0, time_reg} + {1'b0, max_reg};
        end
        idx_reg      <= idx_next;
        own_reg      <= own_next;
        ca2_reg      <= ca2_next;
        own_hit_reg  <= own_hit_next;
        c_clr_reg    <= c_clr_next;
        free_hit_reg <= free_hit_next;
        free_idx_reg <= free_idx_next;
        exp_hit_reg  <= exp_hit_next;
        exp_idx_reg  <= exp_idx_next;
        sel_reg      <= sel_next;
        sel_ok_reg   <= sel_ok_next;
        ack_reg      <= ack_next;
        rel_reg      <= rel_next;
        grant_reg    <= grant_next;
        rk_reg       <= rk_next;
        ra_reg       <= ra_next;
        re_reg       <= re_next;
    end

    assign reply_valid   = rv_reg;
    assign reply_kind    = rk_reg;
    assign reply_client  = client_reg;
    assign reply_address = ra_reg;
    assign reply_expiry  = re_reg;

`ifndef SYNTHESIS
    // a reply only follows the final step of a transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        reply_valid |-> $past(state_reg == S_FIN))
        else $error("reply without finished transaction");

    // a reply is a single-cycle strobe
    assert property (@(posedge clk) disable iff (!rst_n)
        reply_valid |=> !reply_valid)
        else $error("reply strobe longer than one cycle");

    // a negative acknowledge carries no expiry
    assert property (@(posedge clk) disable iff (!rst_n)
        (reply_valid && (reply_kind == alr_pkg::KIND_NAK)) |-> (reply_expiry == '0))
        else $error("nak with nonzero expiry");
`endif

endmodule
`default_nettype wire

// ===== verif/tb.sv =====
// self-checking testbench for the address lease allocator core
`timescale 1ns / 100ps
`default_nettype none
module tb;

    // field widths from the package
    localparam int TIME_W   = alr_pkg::TIME_W;
    localparam int CLIENT_W = alr_pkg::CLIENT_W;
    localparam int ADDR_W   = alr_pkg::ADDR_W;
    localparam int EXP_W    = alr_pkg::EXP_W;
    localparam int PSIZE_W  = alr_pkg::PSIZE_W;

    // codes that the package leaves unnamed
    localparam logic [1:0] CMD_OTHER  = 2'd2;
    localparam logic [1:0] CMD_SPARE  = 2'd3;
    localparam logic [1:0] DEST_SPARE = 2'd3;

    localparam int POOL_N   = alr_pkg::POOL_DEPTH_DEF;
    localparam int CLIENT_N = alr_pkg::CLIENT_DEPTH_DEF;
    // two ring laps plus pipeline, with some margin
    localparam int LAT_CYC  = 2 * POOL_N + 5 + 20;
    localparam int WDOG_LIM = 20000;

    typedef struct packed {
        logic [TIME_W-1:0]   mtime;
        logic [CLIENT_W-1:0] client;
        logic                is_client;
        logic [1:0]          dest;
        logic [1:0]          cmd;
        logic [ADDR_W-1:0]   addr;
        logic [TIME_W-1:0]   req;
    } lease_msg_t;

    typedef struct packed {
        logic [1:0]          kind;
        logic [CLIENT_W-1:0] client;
        logic [ADDR_W-1:0]   addr;
        logic [EXP_W-1:0]    expiry;
    } lease_reply_t;

    // directed row: message, and a typed-in reply where obvious
    typedef struct {
        lease_msg_t   msg;
        bit           typed;
        bit           has_reply;
        lease_reply_t reply;
    } dir_row_t;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic [TIME_W-1:0]   msg_time;
    logic [CLIENT_W-1:0] client_id;
    logic                sender_is_client;
    logic [1:0]          destination;
    logic [1:0]          command;
    logic [ADDR_W-1:0]   address;
    logic [TIME_W-1:0]   requested_expiry;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [1:0]          cfg_index;
    logic [TIME_W-1:0]   cfg_data;
    logic                reply_valid;
    logic [1:0]          reply_kind;
    logic [CLIENT_W-1:0] reply_client;
    logic [ADDR_W-1:0]   reply_address;
    logic [EXP_W-1:0]    reply_expiry;

    address_lease_allocator_core i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .msg_time         (msg_time),
        .client_id        (client_id),
        .sender_is_client (sender_is_client),
        .destination      (destination),
        .command          (command),
        .address          (address),
        .requested_expiry (requested_expiry),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .reply_valid      (reply_valid),
        .reply_kind       (reply_kind),
        .reply_client     (reply_client),
        .reply_address    (reply_address),
        .reply_expiry     (reply_expiry)
    );

    // lease table mirror
    logic [1:0]          lease_status [1:POOL_N];
    logic [CLIENT_W-1:0] lease_owner  [1:POOL_N];
    logic [EXP_W-1:0]    lease_expiry [1:POOL_N];
    logic [PSIZE_W-1:0]  held_addr    [0:CLIENT_N-1];

    logic [PSIZE_W-1:0]  pool_size_r;
    logic [TIME_W-1:0]   default_lease_r;
    logic [TIME_W-1:0]   lease_max_r;
    logic [TIME_W-1:0]   lease_min_r;

    lease_reply_t pending_replies [$];
    dir_row_t     dir_rows [$];
    int           fail_cnt = 0;
    int           idle_cycles = 0;
    logic [TIME_W-1:0] now_t;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // granted expiry, clamped to [t+min, t+max]; upper bound wins when crossed
    function automatic logic [EXP_W-1:0] grant(logic [TIME_W-1:0] t,
                                               logic [TIME_W-1:0] req);
        logic [EXP_W-1:0] lo;
        logic [EXP_W-1:0] hi;
        logic [EXP_W-1:0] e;
        lo = {1'b0, t} + {1'b0, lease_min_r};
        hi = {1'b0, t} + {1'b0, lease_max_r};
        if (req == '0)
            return {1'b0, t} + {1'b0, default_lease_r};
        e = {1'b0, req};
        if (e < lo)
            e = lo;
        if (e > hi)
            e = hi;
        return e;
    endfunction

    // applies one message to the mirror; returns 1 when a reply is due
    function automatic bit lease_update(lease_msg_t m, output lease_reply_t r);
        int n;
        int sel;
        int own;
        n = (pool_size_r > POOL_N) ? POOL_N : int'(pool_size_r);
        r = '0;
        // expiry sweep
        for (int i = 1; i <= n; i++)
        begin
            if ((lease_status[i] == alr_pkg::ST_PENDING
                 || lease_status[i] == alr_pkg::ST_OCCUPIED)
                && {1'b0, m.mtime} >= lease_expiry[i])
            begin
                lease_expiry[i] = '0;
                if (lease_status[i] == alr_pkg::ST_PENDING)
                begin
                    held_addr[lease_owner[i]] = '0;
                    lease_owner[i] = '0;
                    lease_status[i] = alr_pkg::ST_FREE;
                end
                else
                    lease_status[i] = alr_pkg::ST_EXPIRED;
            end
        end
        if (!m.is_client || m.client == '0 || m.client >= CLIENT_N)
            return 0;
        if (m.cmd == alr_pkg::CMD_DISCOVER && m.dest == alr_pkg::DEST_BCAST)
        begin
            sel = 0;
            own = int'(held_addr[m.client]);
            if (own >= 1 && own <= n && lease_owner[own] == m.client)
                sel = own;
            for (int i = 1; i <= n && sel == 0; i++)
                if (lease_status[i] == alr_pkg::ST_FREE)
                    sel = i;
            for (int i = 1; i <= n && sel == 0; i++)
                if (lease_status[i] == alr_pkg::ST_EXPIRED)
                    sel = i;
            if (sel == 0)
                return 0;
            lease_status[sel] = alr_pkg::ST_PENDING;
            lease_owner[sel] = m.client;
            held_addr[m.client] = PSIZE_W'(sel);
            lease_expiry[sel] = grant(m.mtime, m.req);
            r.kind = alr_pkg::KIND_OFFER;
            r.client = m.client;
            r.addr = ADDR_W'(sel);
            r.expiry = lease_expiry[sel];
            return 1;
        end
        if (m.cmd == alr_pkg::CMD_REQUEST && m.dest == alr_pkg::DEST_OTHER)
        begin
            // release every pending lease the client holds
            for (int i = 1; i <= n; i++)
            begin
                if (lease_status[i] == alr_pkg::ST_PENDING && lease_owner[i] == m.client)
                begin
                    lease_status[i] = alr_pkg::ST_FREE;
                    lease_owner[i] = '0;
                    lease_expiry[i] = '0;
                    if (held_addr[m.client] == PSIZE_W'(i))
                        held_addr[m.client] = '0;
                end
            end
            return 0;
        end
        if (m.cmd == alr_pkg::CMD_REQUEST && m.dest == alr_pkg::DEST_HERE)
        begin
            r.client = m.client;
            r.addr = m.addr;
            if (m.addr >= 1 && m.addr <= n && lease_owner[m.addr] == m.client)
            begin
                lease_status[m.addr] = alr_pkg::ST_OCCUPIED;
                lease_expiry[m.addr] = grant(m.mtime, m.req);
                r.kind = alr_pkg::KIND_ACK;
                r.expiry = lease_expiry[m.addr];
            end
            else
            begin
                r.kind = alr_pkg::KIND_NAK;
                r.expiry = '0;
            end
            return 1;
        end
        return 0;
    endfunction

    // drive one message after a random gap; start stays high across back-to-back items
    task automatic send_msg(lease_msg_t m, bit typed, bit has_typed, lease_reply_t tr);
        int gap;
        bit has;
        lease_reply_t r;
        gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 16));
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start            <= 1'b1;
        msg_time         <= m.mtime;
        client_id        <= m.client;
        sender_is_client <= m.is_client;
        destination      <= m.dest;
        command          <= m.cmd;
        address          <= m.addr;
        requested_expiry <= m.req;
        do
            @(posedge clk);
        while (busy);
        // transaction accepted at this edge
        has = lease_update(m, r);
        if (typed)
        begin
            if (has_typed)
                pending_replies.push_back(tr);
        end
        else if (has)
            pending_replies.push_back(r);
    endtask

    // wait for quiet block, then write all four registers back to back
    task automatic set_config(logic [PSIZE_W-1:0] ps, logic [TIME_W-1:0] dl,
                              logic [TIME_W-1:0] mx, logic [TIME_W-1:0] mn);
        logic [TIME_W-1:0] vals [4];
        logic [1:0]        idx  [4];
        start <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (LAT_CYC) @(posedge clk);
        while (busy)
            @(posedge clk);
        vals = '{{{(TIME_W-PSIZE_W){1'b0}}, ps}, dl, mx, mn};
        idx  = '{alr_pkg::CFG_POOL_SIZE, alr_pkg::CFG_DEFAULT, alr_pkg::CFG_MAX,
                 alr_pkg::CFG_MIN};
        for (int k = 0; k < 4; k++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[k];
            cfg_data  <= vals[k];
            do
                @(posedge clk);
            while (!cfg_ready);
            case (idx[k])
                alr_pkg::CFG_POOL_SIZE: pool_size_r     = vals[k][PSIZE_W-1:0];
                alr_pkg::CFG_DEFAULT:   default_lease_r = vals[k];
                alr_pkg::CFG_MAX:       lease_max_r     = vals[k];
                default:                lease_min_r     = vals[k];
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic add_row(logic [TIME_W-1:0] t, int c, bit isc, logic [1:0] d,
                           logic [1:0] cm, int a, logic [TIME_W-1:0] rq,
                           bit typed, bit has, logic [1:0] k, int ra,
                           logic [EXP_W-1:0] re);
        dir_row_t row;
        row.msg = '{t, c[CLIENT_W-1:0], isc, d, cm, a[ADDR_W-1:0], rq};
        row.typed = typed;
        row.has_reply = has;
        row.reply = '{k, c[CLIENT_W-1:0], ra[ADDR_W-1:0], re};
        dir_rows.push_back(row);
    endtask

    // random message biased toward discover/request pairs of a few clients
    task automatic random_msg(int nclients);
        lease_msg_t m;
        int sel;
        logic [32:0] nt;
        nt = {2'b0, now_t} + (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 2500));
        now_t = (nt > 33'h7FFFFFFF) ? 31'h7FFFFFFF : nt[TIME_W-1:0];
        m.mtime = now_t;
        if ($urandom_range(0, 19) == 0)
            m.client = CLIENT_W'($urandom_range(0, 1023));
        else
            m.client = CLIENT_W'($urandom_range(1, nclients));
        m.is_client = 1'b1;
        m.addr = ADDR_W'($urandom_range(0, 65535));
        sel = int'($urandom_range(0, 9));
        if (sel < 4)
            m.req = '0;
        else if (sel < 8)
            m.req = (now_t > 31'h7FFE0000) ? now_t
                  : TIME_W'(now_t + $urandom_range(0, 100000));
        else
            m.req = TIME_W'($urandom_range(0, 32'h7FFFFFFF));
        sel = int'($urandom_range(0, 99));
        if (sel < 40)
        begin
            m.dest = alr_pkg::DEST_BCAST;
            m.cmd = alr_pkg::CMD_DISCOVER;
        end
        else if (sel < 75)
        begin
            m.dest = alr_pkg::DEST_HERE;
            m.cmd = alr_pkg::CMD_REQUEST;
            case ($urandom_range(0, 3))
                0, 1: m.addr = ADDR_W'(held_addr[m.client]);
                2:    m.addr = ADDR_W'($urandom_range(0, int'(pool_size_r) + 1));
                default: ;
            endcase
        end
        else if (sel < 85)
        begin
            m.dest = alr_pkg::DEST_OTHER;
            m.cmd = alr_pkg::CMD_REQUEST;
        end
        else
        begin
            // noise: anything the selectors allow
            m.is_client = 1'($urandom_range(0, 1));
            m.dest = 2'($urandom_range(0, 3));
            m.cmd = 2'($urandom_range(0, 3));
        end
        send_msg(m, 1'b0, 1'b0, '0);
    endtask

    // reply checker: the receiver takes every strobe
    always @(posedge clk)
    begin
        lease_reply_t exp_r;
        if (rst_n && reply_valid)
        begin
            if (pending_replies.size() == 0)
            begin
                $display("%0t: reply with none expected: kind %0d client %0d addr %0d exp %0d",
                         $time, reply_kind, reply_client, reply_address, reply_expiry);
                fail_cnt++;
            end
            else
            begin
                exp_r = pending_replies.pop_front();
                if (reply_kind !== exp_r.kind)
                begin
                    $display("%0t: reply_kind expected %0d actual %0d",
                             $time, exp_r.kind, reply_kind);
                    fail_cnt++;
                end
                if (reply_client !== exp_r.client)
                begin
                    $display("%0t: reply_client expected %0d actual %0d",
                             $time, exp_r.client, reply_client);
                    fail_cnt++;
                end
                if (reply_address !== exp_r.addr)
                begin
                    $display("%0t: reply_address expected %0d actual %0d",
                             $time, exp_r.addr, reply_address);
                    fail_cnt++;
                end
                if (reply_expiry !== exp_r.expiry)
                begin
                    $display("%0t: reply_expiry expected %0d actual %0d",
                             $time, exp_r.expiry, reply_expiry);
                    fail_cnt++;
                end
            end
        end
    end

    // watchdog: cycles without any transaction on any channel
    always @(posedge clk)
    begin
        if ((start && !busy) || reply_valid || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_LIM)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        logic [TIME_W-1:0] max_t;
        max_t = 31'h7FFFFFFF;
        start = 1'b0;
        msg_time = '0;
        client_id = '0;
        sender_is_client = 1'b0;
        destination = '0;
        command = '0;
        address = '0;
        requested_expiry = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        now_t = '0;
        for (int i = 1; i <= POOL_N; i++)
        begin
            lease_status[i] = alr_pkg::ST_FREE;
            lease_owner[i] = '0;
            lease_expiry[i] = '0;
        end
        for (int i = 0; i < CLIENT_N; i++)
            held_addr[i] = '0;
        pool_size_r = alr_pkg::RST_POOL_SIZE;
        default_lease_r = alr_pkg::RST_DEFAULT;
        lease_max_r = alr_pkg::RST_MAX;
        lease_min_r = alr_pkg::RST_MIN;

        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed part at reset settings
        add_row(100, 5, 1, alr_pkg::DEST_BCAST, alr_pkg::CMD_DISCOVER, 0, 0, 1, 1,
                alr_pkg::KIND_OFFER, 1, 3700);
        add_row(100, 6, 1, alr_pkg::DEST_BCAST, alr_pkg::CMD_DISCOVER, 0, 1, 1, 1,
                alr_pkg::KIND_OFFER, 2, 160);
        add_row(100, 7, 1, alr_pkg::DEST_BCAST, alr_pkg::CMD_DISCOVER, 0, max_t, 1, 1,
                alr_pkg::KIND_OFFER, 3, 86500);
        add_row(100, 5, 1, alr_pkg::DEST_HERE, alr_pkg::CMD_REQUEST, 1, 0, 1, 1,
                alr_pkg::KIND_ACK, 1, 3700);
        add_row(100, 6, 1, alr_pkg::DEST_HERE, alr_pkg::CMD_REQUEST, 1, 0, 1, 1,
                alr_pkg::KIND_NAK, 1, 0);
        add_row(100, 5, 1, alr_pkg::DEST_HERE, alr_pkg::CMD_REQUEST, 65535, 0, 1, 1,
                alr_pkg::KIND_NAK, 65535, 0);
        add_row(100, 5, 1, alr_pkg::DEST_HERE, alr_pkg::CMD_REQUEST, 0, 0, 1, 1,
                alr_pkg::KIND_NAK, 0, 0);
        add_row(100, 0, 1, alr_pkg::DEST_BCAST, alr_pkg::CMD_DISCOVER, 0, 0, 1, 0,
                alr_pkg::KIND_OFFER, 0, 0);
        add_row(100, 9, 0, alr_pkg::DEST_BCAST, alr_pkg::CMD_DISCOVER, 0, 0, 1, 0,
                alr_pkg::KIND_OFFER, 0, 0);
        add_row(100, 9, 1, DEST_SPARE, alr_pkg::CMD_DISCOVER, 0, 0, 1, 0,
                alr_pkg::KIND_OFFER, 0, 0);
        add_row(100, 9, 1, alr_pkg::DEST_HERE, alr_pkg::CMD_DISCOVER, 0, 0, 1, 0,
                alr_pkg::KIND_OFFER, 0, 0);
        add_row(100, 9, 1, alr_pkg::DEST_BCAST, alr_pkg::CMD_REQUEST, 1, 0, 1, 0,
                alr_pkg::KIND_OFFER, 0, 0);
        add_row(100, 9, 1, alr_pkg::DEST_HERE, CMD_OTHER, 1, 0, 1, 0,
                alr_pkg::KIND_OFFER, 0, 0);
        add_row(100, 9, 1, alr_pkg::DEST_BCAST, CMD_SPARE, 1, 0, 1, 0,
                alr_pkg::KIND_OFFER, 0, 0);
        // request elsewhere frees the pending lease of client 7
        add_row(100, 7, 1, alr_pkg::DEST_OTHER, alr_pkg::CMD_REQUEST, 0, 0, 1, 0,
                alr_pkg::KIND_OFFER, 0, 0);
        add_row(100, 8, 1, alr_pkg::DEST_BCAST, alr_pkg::CMD_DISCOVER, 0, 0, 1, 1,
                alr_pkg::KIND_OFFER, 3, 3700);
        add_row(100, 5, 1, alr_pkg::DEST_BCAST, alr_pkg::CMD_DISCOVER, 0, 0, 1, 1,
                alr_pkg::KIND_OFFER, 1, 3700);
        add_row(100, 1023, 1, alr_pkg::DEST_BCAST, alr_pkg::CMD_DISCOVER, 0, 0, 1, 1,
                alr_pkg::KIND_OFFER, 4, 3700);
        // later rows rely on the sweep, so the predictor decides them
        add_row(4000, 9, 1, alr_pkg::DEST_BCAST, alr_pkg::CMD_DISCOVER, 0, 0, 0, 0,
                alr_pkg::KIND_OFFER, 0, 0);
        add_row(4000, 9, 1, alr_pkg::DEST_HERE, alr_pkg::CMD_REQUEST, 1, 4100, 0, 0,
                alr_pkg::KIND_OFFER, 0, 0);
        add_row(5000, 10, 1, alr_pkg::DEST_BCAST, alr_pkg::CMD_DISCOVER, 0, 0, 0, 0,
                alr_pkg::KIND_OFFER, 0, 0);
        add_row(5000, 1023, 1, alr_pkg::DEST_HERE, alr_pkg::CMD_REQUEST, 4, 0, 0, 0,
                alr_pkg::KIND_OFFER, 0, 0);
        add_row(9000, 11, 1, alr_pkg::DEST_BCAST, alr_pkg::CMD_DISCOVER, 0, 0, 0, 0,
                alr_pkg::KIND_OFFER, 0, 0);
        foreach (dir_rows[k])
            send_msg(dir_rows[k].msg, dir_rows[k].typed, dir_rows[k].has_reply,
                     dir_rows[k].reply);
        now_t = 31'd9000;

        // random phases across register settings, extremes included
        set_config(11'd4, 31'd500, 31'd2000, 31'd30);
        repeat (45) random_msg(6);
        set_config(11'd1, 31'd1, 31'd1, 31'd1);
        repeat (35) random_msg(3);
        set_config(11'd0, 31'd1000, 31'd5000, 31'd100);
        repeat (15) random_msg(4);
        // crossed limits: maximum bound wins
        set_config(11'd2047, 31'd3000, 31'd200, 31'h7FFFFFFF);
        repeat (45) random_msg(20);
        set_config(11'd8, TIME_W'($urandom_range(1, 5000)), TIME_W'($urandom_range(1000, 90000)),
                   TIME_W'($urandom_range(1, 1000)));
        repeat (50) random_msg(12);
        // top of the time range with the widest leases
        set_config(11'd1024, 31'h7FFFFFFF, 31'h7FFFFFFF, 31'd1);
        now_t = TIME_W'(32'h7FFF0000 | $urandom_range(0, 16'hFFFF));
        repeat (60) random_msg(10);

        start <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (LAT_CYC) @(posedge clk);
        if (fail_cnt == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
`default_nettype wire

// ===== filelist.f =====
sv/alr_pkg.sv
sv/alr_ram.sv
sv/alr_cell.sv
sv/alr_chain.sv
sv/address_lease_allocator_core.sv
verif/tb.sv
